// ----- src/brr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, register codes and coding functions for the BRR block encoder.
// No dependencies; every other file refers to it by scoped names.
package brr_pkg;

   localparam int BlockSamples = 16;
   localparam int SampleWidth  = 16;
   localparam int ShiftMax     = 12;

   // register indexes on the csr port (byte address 4*i)
   localparam logic [1:0] REG_FORMAT = 2'd0;
   localparam logic [1:0] REG_SKIP   = 2'd1;
   localparam logic [1:0] REG_BIAS   = 2'd2;

   typedef struct packed {
      logic [15:0] sample_raw;
      logic        final_sample;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       block_last;
   } rsp_type;

   typedef struct packed {
      logic       sample_format;
      logic [7:0] skip_count;
      logic [7:0] header_bias;
   } cfg_type;

   // one closed block handed from front to back
   typedef struct packed {
      logic [7:0]                               header;
      logic [3:0]                               shift;
      logic [BlockSamples-1:0][SampleWidth-1:0] samples;
   } blk_type;

   // shift 0..12 by power-of-two thresholds 0x8 .. 0x4000
   function automatic logic [3:0] pick_shift(input logic [15:0] peak);
      logic [3:0] s;
      s = 4'd0;
      for (int i = 0; i < ShiftMax; i++) begin
         if (peak >= 16'(16'h0008 << i)) begin
            s = 4'(i + 1);
         end
      end
      return s;
   endfunction

   // sign-magnitude truncation to a 4-bit code
   function automatic logic [3:0] nibble_of(input logic [15:0] v, input logic [3:0] sh);
      logic [15:0] pos;
      logic [16:0] m;
      pos = v >> sh;
      m   = (17'h10000 - {1'b0, v}) >> sh;
      if (!v[15]) begin
         return pos[3:0];
      end
      return 4'h0 - m[3:0];
   endfunction

endpackage

// ----- src/brr_front.sv -----
`timescale 1ns / 1ps
// Front end: sample intake, decimation, format conversion, peak tracking and
// block assembly. Depends on brr_pkg.
module brr_front (
   input  logic             clock,
   input  logic             reset,
   input  brr_pkg::cfg_type cfg,
   input  logic             req_push,
   output logic             req_full,
   input  brr_pkg::req_type req_data,
   output logic             blk_push,
   input  logic             blk_full,
   output brr_pkg::blk_type blk_data
);

   logic [7:0]  skip_left_ff, skip_left_in;
   logic [3:0]  fill_ff, fill_in;
   logic [15:0] peak_ff, peak_in;
   logic [15:0] store_ff [brr_pkg::BlockSamples];

   logic        accept, keep, close;
   logic [15:0] v, mag, peak_new;
   logic [3:0]  sh;

   assign req_full = blk_full;
   assign accept   = req_push && !req_full;

   always_comb begin
      keep = accept && ((skip_left_ff == 8'd0) || req_data.final_sample);
      if (cfg.sample_format) begin
         v = req_data.sample_raw;
      end else begin
         v = {~req_data.sample_raw[7], req_data.sample_raw[6:0], 8'h00};
      end
      mag      = v[15] ? 16'(17'h10000 - {1'b0, v}) : v;
      peak_new = (mag > peak_ff) ? mag : peak_ff;
      close    = keep && (req_data.final_sample || (fill_ff == 4'(brr_pkg::BlockSamples - 1)));
      sh       = brr_pkg::pick_shift(peak_new);

      blk_push        = close;
      blk_data.shift  = sh;
      blk_data.header = 8'({sh, 4'h0} + {7'd0, req_data.final_sample} + cfg.header_bias);
      // entries past the new sample were never written in this block: zero
      for (int i = 0; i < brr_pkg::BlockSamples; i++) begin
         if (4'(i) < fill_ff) begin
            blk_data.samples[i] = store_ff[i];
         end else if (4'(i) == fill_ff) begin
            blk_data.samples[i] = v;
         end else begin
            blk_data.samples[i] = 16'h0000;
         end
      end

      skip_left_in = skip_left_ff;
      fill_in      = fill_ff;
      peak_in      = peak_ff;
      if (accept && !keep) begin
         skip_left_in = skip_left_ff - 8'd1;
      end else if (keep) begin
         skip_left_in = req_data.final_sample ? 8'd0 : cfg.skip_count;
         if (close) begin
            fill_in = 4'd0;
            peak_in = 16'h0000;
         end else begin
            fill_in = fill_ff + 4'd1;
            peak_in = peak_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_left_ff <= 8'd0;
         fill_ff      <= 4'd0;
         peak_ff      <= 16'h0000;
      end else begin
         skip_left_ff <= skip_left_in;
         fill_ff      <= fill_in;
         peak_ff      <= peak_in;
      end
   end

   always_ff @(posedge clock) begin
      if (keep) begin
         store_ff[fill_ff] <= v;
      end
   end

endmodule

// ----- src/brr_fifo.sv -----
`timescale 1ns / 1ps
// Two-entry queue of closed blocks between front and back.
// Depends on brr_pkg for the block type.
module brr_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  brr_pkg::blk_type wr_data,
   output logic             full,
   input  logic             pop,
   output brr_pkg::blk_type rd_data,
   output logic             empty
);

   brr_pkg::blk_type mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- src/brr_back.sv -----
`timescale 1ns / 1ps
// Back end: walks a queued block and emits header plus eight nibble bytes
// through an output register. Depends on brr_pkg.
module brr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             blk_empty,
   input  brr_pkg::blk_type blk_data,
   output logic             blk_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output brr_pkg::rsp_type rsp_data
);

   localparam logic [3:0] LastIdx = 4'(brr_pkg::BlockSamples / 2);

   logic [3:0]       idx_ff, idx_in;
   logic             out_valid_ff, out_valid_in;
   brr_pkg::rsp_type out_ff, out_in;
   logic             load;
   logic [2:0]       pair;
   logic [3:0]       hi, lo;

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      load    = !blk_empty && (!out_valid_ff || rsp_pop);
      pair    = 3'(idx_ff - 4'd1);
      hi      = brr_pkg::nibble_of(blk_data.samples[{pair, 1'b0}], blk_data.shift);
      lo      = brr_pkg::nibble_of(blk_data.samples[{pair, 1'b1}], blk_data.shift);
      blk_pop = load && (idx_ff == LastIdx);

      out_in           = out_ff;
      out_valid_in     = out_valid_ff && !rsp_pop;
      idx_in           = idx_ff;
      if (load) begin
         out_valid_in       = 1'b1;
         out_in.out_byte    = (idx_ff == 4'd0) ? blk_data.header : {hi, lo};
         out_in.block_last  = (idx_ff == LastIdx);
         idx_in             = (idx_ff == LastIdx) ? 4'd0 : idx_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

// ----- src/brr_block_encoder_top.sv -----
`timescale 1ns / 1ps
// Top level of the BRR block encoder: csr registers plus front, block queue
// and back. Depends on brr_pkg, brr_front, brr_fifo and brr_back.
//
// Usage: push PCM sample words on req_* (accepted when req_push is high and
// req_full low). Each kept sample is followed by skip_count dropped ones; a
// word with final_sample set is always kept and closes the block. Every
// sixteen kept samples, or at a final word, the block leaves as nine words on
// rsp_*: the header, then eight bytes of two nibbles each (even sample high);
// block_last marks the ninth. rsp_empty low means rsp_data holds the oldest
// word; rsp_pop takes it.
// Samples go in at one per cycle while req_full is low; the back end emits one
// byte per cycle while rsp_pop is high, nine per block, and a two-block queue
// between them lets the front keep taking samples while a block drains.
// If the receiver stalls, bytes back up into the block queue; once it holds
// two blocks, req_full rises until the back end frees a slot.
// Reset clears the block under assembly, the queue and the output register,
// and sets sample_format to 16-bit, skip_count and header_bias to 0.
// Registers: 0x0 sample_format, 0x4 skip_count, 0x8 header_bias.
module brr_block_encoder_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  brr_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output brr_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   brr_pkg::cfg_type cfg_ff, cfg_in;
   logic             csr_wr;
   logic             blk_push, blk_full, blk_pop, blk_empty;
   brr_pkg::blk_type blk_wr, blk_rd;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_paddr[3:2])
            brr_pkg::REG_FORMAT: cfg_in.sample_format = csr_pwdata[0];
            brr_pkg::REG_SKIP:   cfg_in.skip_count    = csr_pwdata[7:0];
            brr_pkg::REG_BIAS:   cfg_in.header_bias   = csr_pwdata[7:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
      unique case (csr_paddr[3:2])
         brr_pkg::REG_FORMAT: csr_prdata = {31'd0, cfg_ff.sample_format};
         brr_pkg::REG_SKIP:   csr_prdata = {24'd0, cfg_ff.skip_count};
         brr_pkg::REG_BIAS:   csr_prdata = {24'd0, cfg_ff.header_bias};
         default:             csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sample_format <= 1'b1;
         cfg_ff.skip_count    <= 8'd0;
         cfg_ff.header_bias   <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   brr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .blk_push (blk_push),
      .blk_full (blk_full),
      .blk_data (blk_wr)
   );

   brr_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (blk_push),
      .wr_data (blk_wr),
      .full    (blk_full),
      .pop     (blk_pop),
      .rd_data (blk_rd),
      .empty   (blk_empty)
   );

   brr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .blk_empty (blk_empty),
      .blk_data  (blk_rd),
      .blk_pop   (blk_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- verif/brr_byte_checker.sv -----
`timescale 1ns / 1ps
// Byte checker for the BRR block encoder: watches the sample, byte and csr
// channels, predicts every encoded byte and compares. Depends on brr_pkg.
module brr_byte_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic             req_full,
   input  brr_pkg::req_type req_data,
   input  logic             rsp_empty,
   input  logic             rsp_pop,
   input  brr_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic             csr_pready,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output int               fail_count,
   output int               pending_words,
   output int               samples_taken,
   output int               bytes_checked
);

   // shadow registers
   logic        cfg_format;
   logic [7:0]  cfg_skip;
   logic [7:0]  cfg_bias;

   // block under assembly
   logic [15:0] block_store [brr_pkg::BlockSamples];
   int          fill;
   logic [16:0] peak;
   logic [7:0]  skip_left;

   brr_pkg::rsp_type predicted_bytes [$];
   brr_pkg::rsp_type want;

   initial begin
      fail_count    = 0;
      pending_words = 0;
      samples_taken = 0;
      bytes_checked = 0;
   end

   // shift = msb position - 2, capped at 12; 0 below 0x8
   function automatic logic [3:0] shift_for_peak(input logic [16:0] pk);
      logic [3:0] s;
      s = 4'd0;
      for (int b = 3; b <= 16; b++) begin
         if (pk[b]) begin
            s = (b - 2 > brr_pkg::ShiftMax) ? 4'(brr_pkg::ShiftMax) : 4'(b - 2);
         end
      end
      return s;
   endfunction

   // sign-magnitude truncation: magnitude shifted, sign restored mod 16
   function automatic logic [3:0] code_of(input logic [15:0] v, input logic [3:0] sh);
      logic [16:0] mag;
      logic [16:0] q;
      mag = v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
      q   = mag >> sh;
      return v[15] ? (4'h0 - q[3:0]) : q[3:0];
   endfunction

   task automatic close_block(input logic end_flag);
      logic [3:0] sh;
      logic [7:0] hdr;
      logic [3:0] hi;
      logic [3:0] lo;
      sh  = shift_for_peak(peak);
      hdr = {sh, 4'h0} + {7'd0, end_flag} + cfg_bias;
      predicted_bytes.push_back({hdr, 1'b0});
      for (int k = 0; k < brr_pkg::BlockSamples / 2; k++) begin
         hi = (2 * k < fill) ? code_of(block_store[2 * k], sh) : 4'h0;
         lo = (2 * k + 1 < fill) ? code_of(block_store[2 * k + 1], sh) : 4'h0;
         predicted_bytes.push_back({hi, lo, 1'(k == brr_pkg::BlockSamples / 2 - 1)});
      end
      foreach (block_store[i]) block_store[i] = 16'h0000;
      fill = 0;
      peak = 17'd0;
   endtask

   task automatic take_sample(input brr_pkg::req_type w);
      logic [15:0] v;
      logic [16:0] mag;
      if (skip_left != 8'd0 && !w.final_sample) begin
         skip_left = skip_left - 8'd1;
      end else begin
         // 8-bit mode: (d - 128) << 8, i.e. the byte with its top bit flipped
         v   = cfg_format ? w.sample_raw : {w.sample_raw[7:0] ^ 8'h80, 8'h00};
         mag = v[15] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
         block_store[fill % brr_pkg::BlockSamples] = v;
         fill++;
         if (mag > peak) peak = mag;
         skip_left = cfg_skip;
         if (w.final_sample) begin
            skip_left = 8'd0;
            close_block(1'b1);
         end else if (fill >= brr_pkg::BlockSamples) begin
            close_block(1'b0);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_format = 1'b1;
         cfg_skip   = 8'd0;
         cfg_bias   = 8'd0;
         foreach (block_store[i]) block_store[i] = 16'h0000;
         fill      = 0;
         peak      = 17'd0;
         skip_left = 8'd0;
         predicted_bytes.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               brr_pkg::REG_FORMAT: cfg_format = csr_pwdata[0];
               brr_pkg::REG_SKIP:   cfg_skip   = csr_pwdata[7:0];
               brr_pkg::REG_BIAS:   cfg_bias   = csr_pwdata[7:0];
               default: ;
            endcase
         end
         if (req_push && !req_full) begin
            samples_taken++;
            take_sample(req_data);
         end
         if (rsp_pop && !rsp_empty) begin
            bytes_checked++;
            if (predicted_bytes.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected word: expected none, actual byte %h last %b",
                        $time, rsp_data.out_byte, rsp_data.block_last);
            end else begin
               want = predicted_bytes.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  fail_count++;
                  $display("%0t: out_byte mismatch: expected %h, actual %h",
                           $time, want.out_byte, rsp_data.out_byte);
               end
               if (rsp_data.block_last !== want.block_last) begin
                  fail_count++;
                  $display("%0t: block_last mismatch: expected %b, actual %b",
                           $time, want.block_last, rsp_data.block_last);
               end
            end
         end
      end
      pending_words = predicted_bytes.size();
   end

endmodule

// ----- verif/tb_brr_block_encoder_top.sv -----
`timescale 1ns / 1ps
// BRR encoder testbench top: clock, reset, sample and csr stimulus, receiver
// pacing and verdict. Uses brr_pkg, brr_block_encoder_top and brr_byte_checker.
module tb_brr_block_encoder_top;

   localparam int CycleLimit   = 300000;
   localparam int SettleCycles = 8;
   localparam int HoldCycles   = 400;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_push    = 1'b0;
   logic             req_full;
   brr_pkg::req_type req_data    = '0;
   logic             rsp_empty;
   logic             rsp_pop     = 1'b0;
   brr_pkg::rsp_type rsp_data;
   logic             csr_psel    = 1'b0;
   logic             csr_penable = 1'b0;
   logic             csr_pwrite  = 1'b0;
   logic [3:0]       csr_paddr   = 4'h0;
   logic [31:0]      csr_pwdata  = 32'h0;
   logic [31:0]      csr_prdata;
   logic             csr_pready;

   int fail_count;
   int pending_words;
   int samples_taken;
   int bytes_checked;
   int cycles = 0;
   int settings_used = 0;

   // pacing controls shared with the receiver
   logic sender_steady = 1'b0;
   logic rsp_steady    = 1'b0;
   logic rsp_hold_req  = 1'b0;

   brr_block_encoder_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   brr_byte_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data      (req_data),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_data      (rsp_data),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_pready    (csr_pready),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .fail_count    (fail_count),
      .pending_words (pending_words),
      .samples_taken (samples_taken),
      .bytes_checked (bytes_checked)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver: random pops, steady stretches, and one long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_pop <= 1'b0;
            for (int n = 0; n < HoldCycles; n++) @(posedge clock);
         end else begin
            rsp_pop <= rsp_steady || ($urandom_range(99) >= 28);
         end
      end
   end

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_word(input logic [15:0] raw, input logic fin);
      req_data <= '{sample_raw: raw, final_sample: fin};
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (!sender_steady && $urandom_range(99) < 28) begin
         req_push <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   // stop offering and let every predicted byte come out
   task automatic drain_block();
      req_push <= 1'b0;
      @(posedge clock);
      wait (pending_words == 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic set_config(input logic fmt, input logic [7:0] skip, input logic [7:0] bias);
      write_reg(brr_pkg::REG_FORMAT, {31'd0, fmt});
      write_reg(brr_pkg::REG_SKIP, {24'd0, skip});
      write_reg(brr_pkg::REG_BIAS, {24'd0, bias});
      settings_used++;
   endtask

   initial begin
      logic [15:0] edge_words [16];
      logic [15:0] raw;
      logic        fin;
      int          n_items;
      int          final_pct;

      edge_words = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0007, 16'h0008,
                     16'hFFF8, 16'hFFF9, 16'h4000, 16'hC000, 16'h3FFF, 16'h0001,
                     16'h8001, 16'h00FF, 16'h1234, 16'hFEDC};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: 16-bit, no skip, no bias; one full block of extremes
      settings_used = 1;
      foreach (edge_words[i]) send_word(edge_words[i], 1'b0);
      // short block closed by a final word, tiny values give shift 0
      send_word(16'h0005, 1'b0);
      send_word(16'hFFFB, 1'b0);
      send_word(16'h0003, 1'b1);
      drain_block();

      // 8-bit, widest skip, header bias wraps; final kept while skipping
      set_config(1'b0, 8'hFF, 8'hFF);
      send_word(16'h00FF, 1'b0);
      send_word(16'hAB80, 1'b0);
      send_word(16'h1200, 1'b1);
      // skip cleared after the final block: this one is kept at once
      send_word(16'h5A00, 1'b1);
      drain_block();

      for (int phase = 0; phase < 5; phase++) begin
         n_items   = 42;
         final_pct = 6;
         case (phase)
            0: set_config(1'b1, 8'd0, 8'd0);
            1: begin
               set_config(1'b0, 8'd1, 8'h80);
               sender_steady = 1'b1;
               rsp_steady    = 1'b1;
            end
            2: begin
               // receiver stalls while samples keep coming: the queue fills
               set_config(1'b1, 8'd0, 8'($urandom_range(255)));
               n_items       = 70;
               final_pct     = 0;
               sender_steady = 1'b1;
               rsp_hold_req  = 1'b1;
            end
            3: set_config(1'($urandom_range(1)), 8'($urandom_range(3)), 8'hFF);
            default: set_config(1'b1, 8'd2, 8'($urandom_range(255)));
         endcase
         for (int i = 0; i < n_items; i++) begin
            raw = 16'($urandom);
            // mostly scaled-down values so every shift gets used
            if ($urandom_range(3) != 0) raw = 16'($signed(raw) >>> $urandom_range(15));
            fin = ($urandom_range(99) < final_pct);
            send_word(raw, fin);
         end
         drain_block();
         sender_steady = 1'b0;
         rsp_steady    = 1'b0;
      end

      repeat (20) @(posedge clock);
      $display("Covered %0d samples and %0d encoded bytes over %0d register settings,",
               samples_taken, bytes_checked, settings_used);
      $display("including 8/16-bit formats, skip 0..255, wrapped headers and a full-queue stall.");
      if (fail_count == 0 && pending_words == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- brr_block_encoder_top.f -----
src/brr_pkg.sv
src/brr_front.sv
src/brr_fifo.sv
src/brr_back.sv
src/brr_block_encoder_top.sv
verif/brr_byte_checker.sv
verif/tb_brr_block_encoder_top.sv
